### design/ppr_pkg.sv
// Package for the page pin reference count table.
// Holds the field widths, action codes, queue command and table entry types.
// No dependencies.
package ppr_pkg;

    localparam int ADDR_W  = 48;
    localparam int LEN_W   = 24;
    localparam int PAGE_W  = 42;
    localparam int CNT_W   = 16;
    localparam int SHIFT_W = 5;
    localparam int NPG_W   = 7;     // page count of one walk, up to 64
    localparam int SUM_W   = 26;    // offset + length + page size - 1

    localparam logic [SHIFT_W-1:0] SHIFT_MIN   = 5'd6;
    localparam logic [SHIFT_W-1:0] SHIFT_MAX   = 5'd20;
    localparam logic [SHIFT_W-1:0] SHIFT_RESET = 5'd12;
    localparam logic [CNT_W-1:0]   CNT_MAX     = 16'hFFFF;
    localparam logic [PAGE_W-1:0]  PAGE_ALL    = {PAGE_W{1'b1}};

    localparam logic OP_ADD    = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    typedef enum logic [2:0] {
        ACT_RAISED    = 3'd0,
        ACT_PIN       = 3'd1,
        ACT_LOWERED   = 3'd2,
        ACT_UNPIN     = 3'd3,
        ACT_UNTRACKED = 3'd4,
        ACT_FULL      = 3'd5,
        ACT_OVERFLOW  = 3'd6,
        ACT_SPAN      = 3'd7
    } t_action;

    typedef struct packed {
        logic              op;
        logic              span;    // range too long, reject with one result
        logic [PAGE_W-1:0] first;
        logic [PAGE_W-1:0] mask;    // page number wrap mask
        logic [NPG_W-1:0]  npages;
    } t_cmd;

    typedef struct packed {
        logic              valid;
        logic [PAGE_W-1:0] page;
        logic [CNT_W-1:0]  count;
    } t_entry;

    localparam int ENT_W = $bits(t_entry);

endpackage

### design/ppr_if.sv
// Handshake interfaces for the request and result channels.
// Depends on ppr_pkg for the field widths.
interface ppr_req_if;
    logic                        valid;
    logic                        ready;
    logic                        op;
    logic [ppr_pkg::ADDR_W-1:0]  address;
    logic [ppr_pkg::LEN_W-1:0]   length;

    modport source (output valid, output op, output address, output length, input ready);
    modport sink   (input valid, input op, input address, input length, output ready);
endinterface

interface ppr_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [ppr_pkg::PAGE_W-1:0]  page_number;
    logic [2:0]                  action;
    logic [ppr_pkg::CNT_W-1:0]   count_now;
    logic                        last;

    modport source (output valid, output page_number, output action, output count_now,
                    output last, input ready);
    modport sink   (input valid, input page_number, input action, input count_now,
                    input last, output ready);
endinterface

### design/ppr_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module ppr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_re) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule

### design/ppr_front.sv
// Front end: holds page_shift, accepts requests, works out first page, page count
// and wrap mask, and pushes walk commands into the queue. Depends on ppr_pkg, ppr_if.
module ppr_front #(
    parameter int MAX_PAGES = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_hold,
    input  logic                          i_cfg_we,
    input  logic [ppr_pkg::SHIFT_W-1:0]   i_cfg_wdata,
    ppr_req_if.sink                       i_req,
    input  logic                          i_q_full,
    output logic                          o_q_push,
    output ppr_pkg::t_cmd                 o_q_cmd
);
    import ppr_pkg::*;

    logic [SHIFT_W-1:0] r_page_shift;
    logic [SHIFT_W-1:0] shift;
    logic [19:0]        low_mask;
    logic [SUM_W-1:0]   sum;
    logic [SUM_W-1:0]   npages;
    logic [ADDR_W-1:0]  first_full;
    logic               accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_page_shift <= SHIFT_RESET;
        end else if (i_cfg_we) begin
            r_page_shift <= i_cfg_wdata;
        end
    end

    always_comb begin
        priority if (r_page_shift < SHIFT_MIN) begin
            shift = SHIFT_MIN;
        end else if (r_page_shift > SHIFT_MAX) begin
            shift = SHIFT_MAX;
        end else begin
            shift = r_page_shift;
        end
    end

    assign low_mask   = ~(20'hFFFFF << shift);
    assign sum        = {6'd0, i_req.address[19:0] & low_mask} + {2'd0, i_req.length}
                        + {6'd0, low_mask};
    assign npages     = sum >> shift;
    assign first_full = i_req.address >> shift;

    assign i_req.ready = !i_q_full && !i_hold;
    assign accept      = i_req.valid && i_req.ready;
    assign o_q_push    = accept && (npages != '0);

    always_comb begin
        o_q_cmd.op     = i_req.op;
        o_q_cmd.span   = npages > SUM_W'(MAX_PAGES);
        o_q_cmd.first  = first_full[PAGE_W-1:0];
        o_q_cmd.mask   = PAGE_ALL >> (shift - SHIFT_MIN);
        o_q_cmd.npages = npages[NPG_W-1:0];
    end
endmodule

### design/ppr_cmd_fifo.sv
// Short command queue between front end and table walker.
// Depends on ppr_pkg for the command type.
module ppr_cmd_fifo #(
    parameter int DEPTH = 2
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  ppr_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output ppr_pkg::t_cmd o_cmd,
    output logic          o_full,
    output logic          o_empty
);
    import ppr_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_cmd          r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;

    assign o_full  = r_count == CW'(DEPTH);
    assign o_empty = r_count == '0;
    assign o_cmd   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end
endmodule

### design/ppr_back.sv
// Table walker: clears the table after reset, then walks each command's pages,
// scanning the entry RAM, updating counts and driving the result register.
// Depends on ppr_pkg, ppr_if and ppr_ram.
module ppr_back #(
    parameter int ENTRIES = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  ppr_pkg::t_cmd i_q_cmd,
    input  logic          i_q_empty,
    output logic          o_q_pop,
    output logic          o_clearing,
    ppr_rsp_if.source     o_rsp
);
    import ppr_pkg::*;

    localparam int IW = $clog2(ENTRIES);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_APPLY,
        ST_SPAN
    } t_state;

    t_state            r_state;
    logic [IW-1:0]     r_clr_idx;
    logic              r_op;
    logic [PAGE_W-1:0] r_page;
    logic [PAGE_W-1:0] r_mask;
    logic [NPG_W-1:0]  r_left;
    logic [IW-1:0]     r_rd_idx;
    logic              r_issue_end;
    logic              r_chk_vld;
    logic [IW-1:0]     r_chk_idx;
    logic              r_hit;
    logic [IW-1:0]     r_hit_idx;
    logic [CNT_W-1:0]  r_hit_cnt;
    logic              r_free_vld;
    logic [IW-1:0]     r_free_idx;
    logic              r_out_vld;
    logic [PAGE_W-1:0] r_out_page;
    t_action           r_out_act;
    logic [CNT_W-1:0]  r_out_cnt;
    logic              r_out_last;

    logic              out_free;
    logic [ENT_W-1:0]  rd_data;
    t_entry            rd_ent;
    logic              match;
    logic              ram_we;
    logic [IW-1:0]     ram_wr_addr;
    t_entry            ram_wr_ent;
    logic              ram_re;
    t_action           ap_act;
    logic [CNT_W-1:0]  ap_cnt;
    logic              ap_stop;
    logic              ap_wr;
    logic [IW-1:0]     ap_idx;
    t_entry            ap_ent;
    logic              page_last;

    ppr_ram #(
        .WIDTH (ENT_W),
        .DEPTH (ENTRIES)
    ) u_table (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_ent),
        .i_re      (ram_re),
        .i_rd_addr (r_rd_idx),
        .o_rd_data (rd_data)
    );

    assign out_free   = !r_out_vld || o_rsp.ready;
    assign rd_ent     = t_entry'(rd_data);
    assign match      = r_chk_vld && rd_ent.valid && (rd_ent.page == r_page);
    assign page_last  = r_left == NPG_W'(1);
    assign o_q_pop    = (r_state == ST_IDLE) && !i_q_empty;
    assign o_clearing = r_state == ST_CLEAR;
    assign ram_re     = (r_state == ST_SCAN) && !r_issue_end;

    always_comb begin
        ap_act       = ACT_RAISED;
        ap_cnt       = '0;
        ap_stop      = 1'b0;
        ap_wr        = 1'b0;
        ap_idx       = r_hit_idx;
        ap_ent.valid = 1'b1;
        ap_ent.page  = r_page;
        ap_ent.count = '0;
        if (r_op == OP_ADD) begin
            if (r_hit) begin
                if (r_hit_cnt == CNT_MAX) begin
                    ap_act  = ACT_OVERFLOW;
                    ap_cnt  = CNT_MAX;
                    ap_stop = 1'b1;
                end else begin
                    ap_act = ACT_RAISED;
                    ap_cnt = r_hit_cnt + 1'b1;
                    ap_wr  = 1'b1;
                end
            end else if (r_free_vld) begin
                ap_act = ACT_PIN;
                ap_cnt = CNT_W'(1);
                ap_wr  = 1'b1;
                ap_idx = r_free_idx;
            end else begin
                ap_act  = ACT_FULL;
                ap_stop = 1'b1;
            end
        end else begin
            if (!r_hit) begin
                ap_act  = ACT_UNTRACKED;
                ap_stop = 1'b1;
            end else if (r_hit_cnt <= CNT_W'(1)) begin
                ap_act       = ACT_UNPIN;
                ap_wr        = 1'b1;
                ap_ent.valid = 1'b0;
            end else begin
                ap_act = ACT_LOWERED;
                ap_cnt = r_hit_cnt - 1'b1;
                ap_wr  = 1'b1;
            end
        end
        ap_ent.count = ap_cnt;
    end

    always_comb begin
        if (r_state == ST_CLEAR) begin
            ram_we      = 1'b1;
            ram_wr_addr = r_clr_idx;
            ram_wr_ent  = '0;
        end else begin
            ram_we      = (r_state == ST_APPLY) && out_free && ap_wr;
            ram_wr_addr = ap_idx;
            ram_wr_ent  = ap_ent;
        end
    end

    assign o_rsp.valid       = r_out_vld;
    assign o_rsp.page_number = r_out_page;
    assign o_rsp.action      = r_out_act;
    assign o_rsp.count_now   = r_out_cnt;
    assign o_rsp.last        = r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_idx   <= '0;
            r_out_vld   <= 1'b0;
            r_chk_vld   <= 1'b0;
            r_issue_end <= 1'b0;
            r_hit       <= 1'b0;
            r_free_vld  <= 1'b0;
            r_rd_idx    <= '0;
        end else begin
            if (o_rsp.ready) begin
                r_out_vld <= 1'b0;
            end
            unique case (r_state)
                ST_CLEAR: begin
                    if (r_clr_idx == IW'(ENTRIES - 1)) begin
                        r_state <= ST_IDLE;
                    end else begin
                        r_clr_idx <= r_clr_idx + 1'b1;
                    end
                end
                ST_IDLE: begin
                    if (!i_q_empty) begin
                        r_op        <= i_q_cmd.op;
                        r_page      <= i_q_cmd.first;
                        r_mask      <= i_q_cmd.mask;
                        r_left      <= i_q_cmd.npages;
                        r_rd_idx    <= '0;
                        r_issue_end <= 1'b0;
                        r_chk_vld   <= 1'b0;
                        r_hit       <= 1'b0;
                        r_free_vld  <= 1'b0;
                        r_state     <= i_q_cmd.span ? ST_SPAN : ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (!r_issue_end) begin
                        r_chk_vld <= 1'b1;
                        r_chk_idx <= r_rd_idx;
                        if (r_rd_idx == IW'(ENTRIES - 1)) begin
                            r_issue_end <= 1'b1;
                        end else begin
                            r_rd_idx <= r_rd_idx + 1'b1;
                        end
                    end else begin
                        r_chk_vld <= 1'b0;
                    end
                    if (match) begin
                        r_hit     <= 1'b1;
                        r_hit_idx <= r_chk_idx;
                        r_hit_cnt <= rd_ent.count;
                        r_state   <= ST_APPLY;
                    end else if (r_chk_vld) begin
                        if (!rd_ent.valid && !r_free_vld) begin
                            r_free_vld <= 1'b1;
                            r_free_idx <= r_chk_idx;
                        end
                        if (r_chk_idx == IW'(ENTRIES - 1)) begin
                            r_state <= ST_APPLY;
                        end
                    end
                end
                ST_APPLY: begin
                    if (out_free) begin
                        r_out_vld  <= 1'b1;
                        r_out_page <= r_page;
                        r_out_act  <= ap_act;
                        r_out_cnt  <= ap_cnt;
                        r_out_last <= ap_stop || page_last;
                        if (ap_stop || page_last) begin
                            r_state <= ST_IDLE;
                        end else begin
                            r_page      <= (r_page + 1'b1) & r_mask;
                            r_left      <= r_left - 1'b1;
                            r_rd_idx    <= '0;
                            r_issue_end <= 1'b0;
                            r_chk_vld   <= 1'b0;
                            r_hit       <= 1'b0;
                            r_free_vld  <= 1'b0;
                            r_state     <= ST_SCAN;
                        end
                    end
                end
                ST_SPAN: begin
                    if (out_free) begin
                        r_out_vld  <= 1'b1;
                        r_out_page <= r_page;
                        r_out_act  <= ACT_SPAN;
                        r_out_cnt  <= '0;
                        r_out_last <= 1'b1;
                        r_state    <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end
endmodule

### design/page_pin_refcount_table.sv
// Page pin reference count table: each request adds or removes one pin on every
// page its byte range touches and returns one result per page visited, the final
// one marked last. The per-page counts live in an ENTRIES-deep RAM that is searched
// one entry per cycle through its single read port. A hit stops the search at the
// matching entry; a miss reads every entry. Each request takes its command from the
// queue before its walk, and a range rejected as too long gives a single result.
// A range that is page aligned and empty gives no result. After reset a clearing
// pass writes every entry before the first request is taken. A two-deep command
// queue lets the next request be taken while a walk runs.
// Depends on ppr_pkg, ppr_if, ppr_front, ppr_cmd_fifo, ppr_back.
module page_pin_refcount_table #(
    parameter int ENTRIES   = 64,
    parameter int MAX_PAGES = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    ppr_req_if.sink                     i_req,
    ppr_rsp_if.source                   o_rsp,
    input  logic                        i_cfg_we,
    input  logic [ppr_pkg::SHIFT_W-1:0] i_cfg_wdata
);
    import ppr_pkg::*;

    t_cmd q_in_cmd;
    t_cmd q_out_cmd;
    logic q_push;
    logic q_pop;
    logic q_full;
    logic q_empty;
    logic clearing;

    ppr_front #(
        .MAX_PAGES (MAX_PAGES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_hold      (clearing),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (i_req),
        .i_q_full    (q_full),
        .o_q_push    (q_push),
        .o_q_cmd     (q_in_cmd)
    );

    ppr_cmd_fifo #(
        .DEPTH (2)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_in_cmd),
        .i_pop   (q_pop),
        .o_cmd   (q_out_cmd),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    ppr_back #(
        .ENTRIES (ENTRIES)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_cmd    (q_out_cmd),
        .i_q_empty  (q_empty),
        .o_q_pop    (q_pop),
        .o_clearing (clearing),
        .o_rsp      (o_rsp)
    );
endmodule

### tb/sv/tb_page_pin_refcount_table.sv
// Self-checking testbench for page_pin_refcount_table: per-page pin counts, walk results.
// Predicts every page result from its own copy of the count table and page shift.
// Depends on ppr_pkg, ppr_if and the design top.
`timescale 1ns / 1ps

module tb_page_pin_refcount_table;
    import ppr_pkg::*;

    localparam int TBL_DEPTH  = 64;
    localparam int SPAN_LIMIT = 64;
    localparam int SETTLE     = 2 * TBL_DEPTH + 16;
    localparam logic [63:0] ADDR_MASK = 64'h0000_FFFF_FFFF_FFFF;
    localparam logic [ADDR_W-1:0] OVF_BASE = 48'hABC_DEF0_0000;

    typedef enum logic [1:0] {
        JOB_REQ,
        JOB_CFG,
        JOB_DRAIN
    } t_job_kind;

    typedef struct {
        t_job_kind          kind;
        logic               op;
        logic [ADDR_W-1:0]  address;
        logic [LEN_W-1:0]   length;
        logic [SHIFT_W-1:0] shift;
        bit                 calm;
    } t_job;

    typedef struct {
        logic [PAGE_W-1:0] page;
        t_action           act;
        logic [CNT_W-1:0]  count;
        logic              last;
    } t_page_result;

    typedef struct {
        logic [ADDR_W-1:0] address;
        logic [LEN_W-1:0]  length;
    } t_span;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               cfg_we    = 1'b0;
    logic [SHIFT_W-1:0] cfg_wdata = SHIFT_RESET;
    logic               req_valid = 1'b0;
    logic               req_op    = OP_ADD;
    logic [ADDR_W-1:0]  req_addr  = '0;
    logic [LEN_W-1:0]   req_len   = '0;
    logic               rsp_ready = 1'b0;
    logic               quiet_rsp = 1'b0;

    ppr_req_if req_ch ();
    ppr_rsp_if rsp_ch ();

    assign req_ch.valid   = req_valid;
    assign req_ch.op      = req_op;
    assign req_ch.address = req_addr;
    assign req_ch.length  = req_len;
    assign rsp_ch.ready   = rsp_ready;

    page_pin_refcount_table #(
        .ENTRIES   (TBL_DEPTH),
        .MAX_PAGES (SPAN_LIMIT)
    ) dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_req       (req_ch),
        .o_rsp       (rsp_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    // predicted table
    bit                 pin_valid [TBL_DEPTH];
    logic [PAGE_W-1:0]  pin_page  [TBL_DEPTH];
    logic [CNT_W-1:0]   pin_count [TBL_DEPTH];
    logic [SHIFT_W-1:0] cur_shift = SHIFT_RESET;

    t_page_result page_results_due [$];
    t_job         job_q [$];
    t_span        live_spans [$];
    int unsigned  gen_shift = 12;
    int           bad = 0;

    initial begin
        forever #6 clk = ~clk;
    end

    function automatic void note_result(input logic [63:0] pg, input t_action act,
                                        input logic [CNT_W-1:0] cnt, input logic last);
        t_page_result r;
        r.page  = pg[PAGE_W-1:0];
        r.act   = act;
        r.count = cnt;
        r.last  = last;
        page_results_due.push_back(r);
    endfunction

    function automatic void walk_range(input logic op, input logic [ADDR_W-1:0] addr,
                                       input logic [LEN_W-1:0] len);
        int unsigned s;
        logic [63:0] size, start, end_a, npages, pg, p;
        logic        lastp;
        int          hit, spare;
        if (cur_shift < SHIFT_MIN) s = SHIFT_MIN;
        else if (cur_shift > SHIFT_MAX) s = SHIFT_MAX;
        else s = cur_shift;
        size   = 64'd1 << s;
        start  = {16'd0, addr} & ~(size - 64'd1);
        end_a  = {16'd0, addr} + {40'd0, len};
        npages = (end_a - start + size - 64'd1) >> s;
        if (npages == 0) return;
        if (npages > SPAN_LIMIT) begin
            note_result(start >> s, ACT_SPAN, '0, 1'b1);
            return;
        end
        for (p = 0; p < npages; p++) begin
            pg    = ((start + (p << s)) & ADDR_MASK) >> s;
            lastp = (p + 1 == npages);
            hit   = -1;
            for (int i = 0; i < TBL_DEPTH; i++)
                if (hit < 0 && pin_valid[i] && pin_page[i] == pg[PAGE_W-1:0]) hit = i;
            if (op == OP_ADD) begin
                if (hit < 0) begin
                    spare = -1;
                    for (int i = 0; i < TBL_DEPTH; i++)
                        if (spare < 0 && !pin_valid[i]) spare = i;
                    if (spare < 0) begin
                        note_result(pg, ACT_FULL, '0, 1'b1);
                        return;
                    end
                    pin_valid[spare] = 1'b1;
                    pin_page[spare]  = pg[PAGE_W-1:0];
                    pin_count[spare] = 16'd1;
                    note_result(pg, ACT_PIN, 16'd1, lastp);
                end else if (pin_count[hit] == CNT_MAX) begin
                    note_result(pg, ACT_OVERFLOW, CNT_MAX, 1'b1);
                    return;
                end else begin
                    pin_count[hit]++;
                    note_result(pg, ACT_RAISED, pin_count[hit], lastp);
                end
            end else begin
                if (hit < 0) begin
                    note_result(pg, ACT_UNTRACKED, '0, 1'b1);
                    return;
                end
                if (pin_count[hit] <= 16'd1) begin
                    pin_count[hit] = '0;
                    pin_valid[hit] = 1'b0;
                    note_result(pg, ACT_UNPIN, '0, lastp);
                end else begin
                    pin_count[hit]--;
                    note_result(pg, ACT_LOWERED, pin_count[hit], lastp);
                end
            end
        end
    endfunction

    // request side: idle bursts, drains and register writes between phases
    always @(posedge clk) begin : feed
        logic hold_valid;
        logic we_next;
        t_job job;
        int   gap_left;
        int   settle;
        if (!rst_n) begin
            req_valid <= 1'b0;
            cfg_we    <= 1'b0;
            gap_left  = 0;
            settle    = 0;
        end else begin
            hold_valid = req_valid;
            we_next    = 1'b0;
            if (req_valid && req_ch.ready) begin
                walk_range(req_op, req_addr, req_len);
                hold_valid = 1'b0;
            end
            if (!hold_valid && job_q.size() != 0) begin
                job = job_q[0];
                if (job.kind == JOB_REQ) begin
                    if (gap_left != 0) begin
                        gap_left--;
                    end else if (!job.calm && $urandom_range(0, 4) == 0) begin
                        gap_left = $urandom_range(1, 5) - 1;
                    end else begin
                        req_op     <= job.op;
                        req_addr   <= job.address;
                        req_len    <= job.length;
                        quiet_rsp  <= job.calm;
                        hold_valid = 1'b1;
                        void'(job_q.pop_front());
                    end
                end else if (page_results_due.size() != 0) begin
                    settle = 0;
                end else if (settle < SETTLE) begin
                    settle++;
                end else begin
                    settle = 0;
                    if (job.kind == JOB_CFG) begin
                        we_next   = 1'b1;
                        cfg_wdata <= job.shift;
                        cur_shift = job.shift;
                    end
                    void'(job_q.pop_front());
                end
            end
            req_valid <= hold_valid;
            cfg_we    <= we_next;
        end
    end

    // result side: random stalls, in-order check against the predicted pages
    always @(posedge clk) begin : watch
        t_page_result want;
        int           stall_left;
        logic         rdy;
        if (!rst_n) begin
            rsp_ready  <= 1'b0;
            stall_left = 0;
        end else begin
            if (rsp_ch.valid && rsp_ready) begin
                if (page_results_due.size() == 0) begin
                    bad++;
                    if (bad <= 10)
                        $display("unexpected transfer: page %h action %0d count %0d last %0d",
                                 rsp_ch.page_number, rsp_ch.action, rsp_ch.count_now,
                                 rsp_ch.last);
                end else begin
                    want = page_results_due.pop_front();
                    if (rsp_ch.page_number !== want.page || rsp_ch.action !== want.act ||
                        rsp_ch.count_now !== want.count || rsp_ch.last !== want.last) begin
                        bad++;
                        if (bad <= 10) begin
                            $display("mismatch: expected page %h action %0d count %0d last %0d",
                                     want.page, want.act, want.count, want.last);
                            $display("          got      page %h action %0d count %0d last %0d",
                                     rsp_ch.page_number, rsp_ch.action, rsp_ch.count_now,
                                     rsp_ch.last);
                        end
                    end
                end
            end
            if (stall_left != 0) begin
                stall_left--;
                rdy = 1'b0;
            end else if (!quiet_rsp && $urandom_range(0, 6) == 0) begin
                stall_left = $urandom_range(1, 5) - 1;
                rdy = 1'b0;
            end else begin
                rdy = 1'b1;
            end
            rsp_ready <= rdy;
        end
    end

    function automatic void queue_req(input logic op, input logic [ADDR_W-1:0] addr,
                                      input logic [LEN_W-1:0] len, input bit calm);
        t_job j;
        j.kind    = JOB_REQ;
        j.op      = op;
        j.address = addr;
        j.length  = len;
        j.shift   = '0;
        j.calm    = calm;
        job_q.push_back(j);
    endfunction

    function automatic void queue_pause(input t_job_kind kind, input logic [SHIFT_W-1:0] val);
        t_job j;
        j.kind    = kind;
        j.op      = OP_ADD;
        j.address = '0;
        j.length  = '0;
        j.shift   = val;
        j.calm    = 1'b0;
        job_q.push_back(j);
        if (kind == JOB_CFG)
            gen_shift = (val < SHIFT_MIN) ? SHIFT_MIN : (val > SHIFT_MAX) ? SHIFT_MAX : val;
    endfunction

    // range of a few pages inside the phase window, occasionally a longer one
    function automatic t_span window_span(input logic [ADDR_W-1:0] base);
        t_span       sp;
        int unsigned npg;
        logic [31:0] size, off, len;
        size = 32'd1 << gen_shift;
        npg  = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 16) : $urandom_range(1, 3);
        off  = $urandom & (size - 1);
        len  = $urandom_range(1, npg * size - off);
        if (len > 32'hFF_FFFF) len = 32'hFF_FFFF;
        sp.address = base + $urandom_range(0, 31) * size + off;
        sp.length  = len[LEN_W-1:0];
        return sp;
    endfunction

    function automatic void random_phase(input int n, input int calm_tail);
        logic [ADDR_W-1:0] base, mask;
        t_span             sp;
        bit                calm;
        int                r, idx;
        mask = (48'd1 << gen_shift) - 1;
        base = ADDR_W'({$urandom, $urandom}) & ~mask;
        calm = 1'b0;
        for (int i = 0; i < n; i++) begin
            if (i % 10 == 0) calm = ($urandom_range(0, 3) == 0);
            if (i >= n - calm_tail) calm = 1'b1;
            r = $urandom_range(0, 99);
            if (r < 45 || live_spans.size() == 0) begin
                sp = window_span(base);
                queue_req(OP_ADD, sp.address, sp.length, calm);
                live_spans.push_back(sp);
            end else if (r < 82) begin
                idx = $urandom_range(0, live_spans.size() - 1);
                sp  = live_spans[idx];
                live_spans.delete(idx);
                queue_req(OP_REMOVE, sp.address, sp.length, calm);
            end else if (r < 90) begin
                sp = window_span(base);
                queue_req(OP_REMOVE, sp.address, sp.length, calm);
            end else begin
                sp.address = ADDR_W'({$urandom, $urandom});
                case ($urandom_range(0, 2))
                    0: sp.length = LEN_W'($urandom);
                    1: begin
                        sp.length = '0;
                        if ($urandom_range(0, 1) == 0) sp.address = sp.address & ~mask;
                    end
                    default: sp.length = LEN_W'($urandom_range(1, 4 << gen_shift));
                endcase
                if ($urandom_range(0, 1) == 0) begin
                    queue_req(OP_ADD, sp.address, sp.length, calm);
                    live_spans.push_back(sp);
                end else begin
                    queue_req(OP_REMOVE, sp.address, sp.length, calm);
                end
            end
        end
        while (live_spans.size() != 0) begin
            sp = live_spans.pop_back();
            queue_req(OP_REMOVE, sp.address, sp.length, calm_tail != 0);
        end
        queue_pause(JOB_DRAIN, '0);
    endfunction

    initial begin
        #120_000_000;
        $display("** page_pin_refcount_table: FAILED **");
        $finish;
    end

    initial begin
        queue_req(OP_ADD,    OVF_BASE,                 24'd1,        1'b0);
        queue_req(OP_ADD,    OVF_BASE - 48'h2000 + 5,  24'h3000,     1'b0);
        queue_req(OP_REMOVE, OVF_BASE - 48'h2000,      24'h2000,     1'b0);
        queue_req(OP_REMOVE, OVF_BASE,                 24'h1000,     1'b0);
        queue_req(OP_ADD,    OVF_BASE + 48'hFFF,       24'd0,        1'b0);
        queue_req(OP_ADD,    48'h0,                    24'd0,        1'b0);
        queue_req(OP_ADD,    48'h1,                    24'd0,        1'b0);
        queue_req(OP_ADD,    48'h123,                  24'd16,       1'b0);
        queue_req(OP_REMOVE, 48'h0,                    24'h1000,     1'b0);
        queue_req(OP_REMOVE, 48'hFFF,                  24'd1,        1'b0);
        queue_req(OP_REMOVE, 48'h5000,                 24'd1,        1'b0);
        queue_req(OP_ADD,    48'hFFFF_FFFF_FFFF,       24'h2000,     1'b0);
        queue_req(OP_REMOVE, 48'hFFFF_FFFF_F000,       24'h3000,     1'b0);
        queue_req(OP_ADD,    48'h1000,                 24'h4_0000,   1'b0);
        queue_req(OP_REMOVE, 48'h1000,                 24'h4_0000,   1'b0);
        queue_req(OP_ADD,    48'h1000,                 24'h4_0001,   1'b0);
        queue_req(OP_REMOVE, 48'hFFFF_FFFF_FFFF,       24'hFF_FFFF,  1'b0);
        queue_req(OP_ADD,    48'h0,                    24'hFF_FFFF,  1'b0);
        queue_pause(JOB_DRAIN, '0);

        random_phase(50, 0);
        queue_pause(JOB_CFG, 5'd6);
        random_phase(45, 0);
        queue_pause(JOB_CFG, 5'd20);
        random_phase(45, 0);
        queue_pause(JOB_CFG, 5'd0);
        random_phase(34, 0);
        queue_pause(JOB_CFG, 5'd31);
        random_phase(34, 0);
        queue_pause(JOB_CFG, 5'd13);
        random_phase(34, 0);
        queue_pause(JOB_CFG, 5'd9);
        random_phase(34, 25);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        while (job_q.size() != 0 || req_valid || page_results_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        if (bad == 0)
            $display("** page_pin_refcount_table: PASSED **");
        else
            $display("** page_pin_refcount_table: FAILED **");
        $finish;
    end

endmodule
